// ===== design/retransmit_timeout_tracker_top_macros.svh =====
// Assertion macros shared by the tracker modules.
// Each macro expects clk and rst_n in the scope where it is used.
`ifndef RETRANSMIT_TIMEOUT_TRACKER_TOP_MACROS_SVH
`define RETRANSMIT_TIMEOUT_TRACKER_TOP_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define RTT_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define RTT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/rtt_pkg.sv =====
`default_nettype none

package rtt_pkg;

    // Field widths
    localparam int OP_W    = 2;
    localparam int ID_W    = 16;
    localparam int STAMP_W = 32;
    localparam int RETRY_W = 4;
    localparam int KIND_W  = 3;
    localparam int ENTRY_W = ID_W + STAMP_W + RETRY_W;

    // Table size default
    localparam int TABLE_ENTRIES_DEF = 16;

    // Register reset values
    localparam logic [STAMP_W-1:0] TIMEOUT_RST = 32'd5000;
    localparam logic [RETRY_W-1:0] LIMIT_RST   = 4'd3;

    // Configuration port
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam logic REG_IDX_TIMEOUT = 1'b0;
    localparam logic REG_IDX_LIMIT   = 1'b1;

    // Operation codes
    localparam logic [OP_W-1:0] OP_SEND  = 2'd0;
    localparam logic [OP_W-1:0] OP_ACK   = 2'd1;
    localparam logic [OP_W-1:0] OP_CHECK = 2'd2;

    // Result kinds
    localparam logic [KIND_W-1:0] KIND_TRACKED    = 3'd0;
    localparam logic [KIND_W-1:0] KIND_LINK_DOWN  = 3'd1;
    localparam logic [KIND_W-1:0] KIND_FULL       = 3'd2;
    localparam logic [KIND_W-1:0] KIND_ACK_REMOVE = 3'd3;
    localparam logic [KIND_W-1:0] KIND_ACK_UNKNOWN = 3'd4;
    localparam logic [KIND_W-1:0] KIND_RETRANSMIT = 3'd5;
    localparam logic [KIND_W-1:0] KIND_GIVE_UP    = 3'd6;
    localparam logic [KIND_W-1:0] KIND_NONE       = 3'd7;

    // One table entry as stored in the RAM
    typedef struct packed {
        logic [ID_W-1:0]    id;
        logic [STAMP_W-1:0] stamp;
        logic [RETRY_W-1:0] retries;
    } rtt_entry_t;

    // Results of the shared compare unit
    typedef struct packed {
        logic               id_match;
        logic               due;
        logic               can_retry;
        logic [RETRY_W-1:0] retries_inc;
    } rtt_cmp_t;

endpackage

`default_nettype wire

// ===== design/rtt_ram.sv =====
`default_nettype none

module rtt_ram #(
    parameter int WIDTH = rtt_pkg::ENTRY_W,
    parameter int DEPTH = rtt_pkg::TABLE_ENTRIES_DEF,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [WIDTH-1:0]  wdata,
    input  wire logic              re,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// ===== design/rtt_unit.sv =====
`default_nettype none

module rtt_unit (
    input  wire rtt_pkg::rtt_entry_t                entry,
    input  wire logic [rtt_pkg::ID_W-1:0]           key_id,
    input  wire logic [rtt_pkg::STAMP_W-1:0]        now_ms,
    input  wire logic [rtt_pkg::STAMP_W-1:0]        timeout_ms,
    input  wire logic [rtt_pkg::RETRY_W-1:0]        retry_limit,
    output rtt_pkg::rtt_cmp_t                       res
);

    import rtt_pkg::*;

    logic [STAMP_W-1:0] age;

    // Age wraps modulo 2^32
    assign age = now_ms - entry.stamp;

    // Compare the entry against the key and the limits
    always_comb
    begin
        res.id_match    = (entry.id == key_id);
        res.due         = (age > timeout_ms);
        res.can_retry   = (entry.retries < retry_limit);
        res.retries_inc = entry.retries + RETRY_W'(1);
    end

endmodule

`default_nettype wire

// ===== design/rtt_ctrl.sv =====
`default_nettype none
`include "retransmit_timeout_tracker_top_macros.svh"

module rtt_ctrl #(
    parameter int TABLE_ENTRIES = rtt_pkg::TABLE_ENTRIES_DEF,
    localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    // command side
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic [rtt_pkg::OP_W-1:0]      op,
    input  wire logic [rtt_pkg::ID_W-1:0]      msg_id,
    input  wire logic [rtt_pkg::STAMP_W-1:0]   now_ms,
    input  wire logic                          link_up,
    // result side
    output logic                               result_valid,
    output logic [rtt_pkg::KIND_W-1:0]         kind,
    output logic [rtt_pkg::ID_W-1:0]           event_id,
    output logic [rtt_pkg::RETRY_W-1:0]        retry_count,
    output logic                               was_sent,
    output logic                               last,
    // table RAM
    output logic                               ram_re,
    output logic [IDX_W-1:0]                   ram_raddr,
    output logic                               ram_we,
    output logic [IDX_W-1:0]                   ram_waddr,
    output rtt_pkg::rtt_entry_t                ram_wdata,
    input  wire rtt_pkg::rtt_entry_t           ram_rdata,
    // shared compare unit
    output logic [rtt_pkg::ID_W-1:0]           key_id,
    output logic [rtt_pkg::STAMP_W-1:0]        cur_now,
    input  wire rtt_pkg::rtt_cmp_t             cmp
);

    import rtt_pkg::*;

    localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
    localparam logic [CNT_W-1:0] CNT_END = CNT_W'(TABLE_ENTRIES);

    localparam int ST_W = 1;
    localparam logic [ST_W-1:0] ST_IDLE = 1'b0;
    localparam logic [ST_W-1:0] ST_SCAN = 1'b1;

    logic [ST_W-1:0]          state_reg, state_next;
    logic [CNT_W-1:0]         iss_reg, iss_next;
    logic                     proc_vld_reg, proc_vld_next;
    logic [IDX_W-1:0]         proc_idx_reg, proc_idx_next;
    logic [TABLE_ENTRIES-1:0] valid_reg, valid_next;

    logic [OP_W-1:0]          op_reg, op_next;
    logic [ID_W-1:0]          id_reg, id_next;
    logic [STAMP_W-1:0]       now_reg, now_next;
    logic                     link_reg, link_next;

    logic                     hit_vld_reg, hit_vld_next;
    logic [IDX_W-1:0]         hit_idx_reg, hit_idx_next;
    logic                     free_vld_reg, free_vld_next;
    logic [IDX_W-1:0]         free_idx_reg, free_idx_next;

    logic                     pend_vld_reg, pend_vld_next;
    logic [KIND_W-1:0]        pend_kind_reg, pend_kind_next;
    logic [ID_W-1:0]          pend_id_reg, pend_id_next;
    logic [RETRY_W-1:0]       pend_retry_reg, pend_retry_next;
    logic                     pend_sent_reg, pend_sent_next;

    logic                     result_valid_reg, result_valid_next;
    logic [KIND_W-1:0]        kind_reg, kind_next;
    logic [ID_W-1:0]          event_id_reg, event_id_next;
    logic [RETRY_W-1:0]       retry_count_reg, retry_count_next;
    logic                     was_sent_reg, was_sent_next;
    logic                     last_reg, last_next;

    logic                     entry_on;
    logic                     scan_done;

    assign busy         = (state_reg != ST_IDLE);
    assign key_id       = id_reg;
    assign cur_now      = now_reg;
    assign entry_on     = valid_reg[proc_idx_reg];
    assign scan_done    = (iss_reg == CNT_END) && !proc_vld_reg;

    assign result_valid = result_valid_reg;
    assign kind         = kind_reg;
    assign event_id     = event_id_reg;
    assign retry_count  = retry_count_reg;
    assign was_sent     = was_sent_reg;
    assign last         = last_reg;

    // Sequencer: issue one table read per cycle, handle the entry read the cycle before
    always_comb
    begin
        state_next        = state_reg;
        iss_next          = iss_reg;
        proc_vld_next     = proc_vld_reg;
        proc_idx_next     = proc_idx_reg;
        valid_next        = valid_reg;
        op_next           = op_reg;
        id_next           = id_reg;
        now_next          = now_reg;
        link_next         = link_reg;
        hit_vld_next      = hit_vld_reg;
        hit_idx_next      = hit_idx_reg;
        free_vld_next     = free_vld_reg;
        free_idx_next     = free_idx_reg;
        pend_vld_next     = pend_vld_reg;
        pend_kind_next    = pend_kind_reg;
        pend_id_next      = pend_id_reg;
        pend_retry_next   = pend_retry_reg;
        pend_sent_next    = pend_sent_reg;

        result_valid_next = 1'b0;
        kind_next         = '0;
        event_id_next     = '0;
        retry_count_next  = '0;
        was_sent_next     = 1'b0;
        last_next         = 1'b0;

        ram_re            = 1'b0;
        ram_raddr         = iss_reg[IDX_W-1:0];
        ram_we            = 1'b0;
        ram_waddr         = proc_idx_reg;
        ram_wdata.id      = id_reg;
        ram_wdata.stamp   = now_reg;
        ram_wdata.retries = '0;

        case (state_reg)
            ST_IDLE:
            begin
                proc_vld_next = 1'b0;
                if (start)
                begin
                    op_next   = op;
                    id_next   = msg_id;
                    now_next  = now_ms;
                    link_next = link_up;
                    hit_vld_next  = 1'b0;
                    free_vld_next = 1'b0;
                    pend_vld_next = 1'b0;
                    iss_next      = '0;
                    case (op)
                        OP_SEND:
                        begin
                            if (link_up)
                            begin
                                state_next = ST_SCAN;
                            end
                            else
                            begin
                                // report link down at once, nothing tracked
                                result_valid_next = 1'b1;
                                kind_next         = KIND_LINK_DOWN;
                                event_id_next     = msg_id;
                                last_next         = 1'b1;
                            end
                        end
                        OP_ACK, OP_CHECK:
                        begin
                            state_next = ST_SCAN;
                        end
                        default:
                        begin
                            // undefined op: drop silently
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end

            ST_SCAN:
            begin
                // Issue the next read
                if (iss_reg != CNT_END)
                begin
                    ram_re        = 1'b1;
                    iss_next      = iss_reg + CNT_W'(1);
                    proc_vld_next = 1'b1;
                    proc_idx_next = iss_reg[IDX_W-1:0];
                end
                else
                begin
                    proc_vld_next = 1'b0;
                end

                // Handle the entry whose data just arrived
                if (proc_vld_reg)
                begin
                    case (op_reg)
                        OP_SEND, OP_ACK:
                        begin
                            if (entry_on && cmp.id_match && !hit_vld_reg)
                            begin
                                hit_vld_next = 1'b1;
                                hit_idx_next = proc_idx_reg;
                            end
                            if (!entry_on && !free_vld_reg)
                            begin
                                free_vld_next = 1'b1;
                                free_idx_next = proc_idx_reg;
                            end
                        end
                        OP_CHECK:
                        begin
                            if (entry_on && cmp.due)
                            begin
                                // release the previous event, it is not the final one
                                if (pend_vld_reg)
                                begin
                                    result_valid_next = 1'b1;
                                    kind_next         = pend_kind_reg;
                                    event_id_next     = pend_id_reg;
                                    retry_count_next  = pend_retry_reg;
                                    was_sent_next     = pend_sent_reg;
                                end
                                pend_vld_next = 1'b1;
                                pend_id_next  = ram_rdata.id;
                                if (cmp.can_retry)
                                begin
                                    ram_we            = 1'b1;
                                    ram_wdata.id      = ram_rdata.id;
                                    ram_wdata.retries = cmp.retries_inc;
                                    pend_kind_next    = KIND_RETRANSMIT;
                                    pend_retry_next   = cmp.retries_inc;
                                    pend_sent_next    = link_reg;
                                end
                                else
                                begin
                                    valid_next[proc_idx_reg] = 1'b0;
                                    pend_kind_next    = KIND_GIVE_UP;
                                    pend_retry_next   = ram_rdata.retries;
                                    pend_sent_next    = 1'b0;
                                end
                            end
                        end
                        default:
                        begin
                            hit_vld_next = hit_vld_reg;
                        end
                    endcase
                end

                // Close the transaction once every entry has been handled
                if (scan_done)
                begin
                    state_next        = ST_IDLE;
                    result_valid_next = 1'b1;
                    last_next         = 1'b1;
                    event_id_next     = id_reg;
                    case (op_reg)
                        OP_SEND:
                        begin
                            if (hit_vld_reg || free_vld_reg)
                            begin
                                ram_we    = 1'b1;
                                ram_waddr = hit_vld_reg ? hit_idx_reg : free_idx_reg;
                                valid_next[ram_waddr] = 1'b1;
                                kind_next = KIND_TRACKED;
                            end
                            else
                            begin
                                kind_next = KIND_FULL;
                            end
                        end
                        OP_ACK:
                        begin
                            if (hit_vld_reg)
                            begin
                                valid_next[hit_idx_reg] = 1'b0;
                                kind_next = KIND_ACK_REMOVE;
                            end
                            else
                            begin
                                kind_next = KIND_ACK_UNKNOWN;
                            end
                        end
                        default:
                        begin
                            if (pend_vld_reg)
                            begin
                                kind_next        = pend_kind_reg;
                                event_id_next    = pend_id_reg;
                                retry_count_next = pend_retry_reg;
                                was_sent_next    = pend_sent_reg;
                            end
                            else
                            begin
                                kind_next     = KIND_NONE;
                                event_id_next = '0;
                            end
                        end
                    endcase
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            iss_reg          <= '0;
            proc_vld_reg     <= 1'b0;
            valid_reg        <= '0;
            hit_vld_reg      <= 1'b0;
            free_vld_reg     <= 1'b0;
            pend_vld_reg     <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            iss_reg          <= iss_next;
            proc_vld_reg     <= proc_vld_next;
            valid_reg        <= valid_next;
            hit_vld_reg      <= hit_vld_next;
            free_vld_reg     <= free_vld_next;
            pend_vld_reg     <= pend_vld_next;
            result_valid_reg <= result_valid_next;
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        proc_idx_reg    <= proc_idx_next;
        op_reg          <= op_next;
        id_reg          <= id_next;
        now_reg         <= now_next;
        link_reg        <= link_next;
        hit_idx_reg     <= hit_idx_next;
        free_idx_reg    <= free_idx_next;
        pend_kind_reg   <= pend_kind_next;
        pend_id_reg     <= pend_id_next;
        pend_retry_reg  <= pend_retry_next;
        pend_sent_reg   <= pend_sent_next;
        kind_reg        <= kind_next;
        event_id_reg    <= event_id_next;
        retry_count_reg <= retry_count_next;
        was_sent_reg    <= was_sent_next;
        last_reg        <= last_next;
    end

    // Checks
    `RTT_ASSERT_NOW(a_idle_no_proc, state_reg == ST_IDLE, !proc_vld_reg,
        "entry handled while idle")
    `RTT_ASSERT_NOW(a_last_ends_item, result_valid_reg && last_reg, state_reg == ST_IDLE,
        "final result while still scanning")
    `RTT_ASSERT_NOW(a_inner_in_check, result_valid_reg && !last_reg,
        state_reg == ST_SCAN && op_reg == OP_CHECK, "non-final result outside a check")
    `RTT_ASSERT_NEXT(a_scan_closes, state_reg == ST_SCAN && scan_done,
        state_reg == ST_IDLE && result_valid_reg && last_reg, "scan did not close")

endmodule

`default_nettype wire

// ===== design/retransmit_timeout_tracker_top.sv =====
`default_nettype none

// Retransmission timer table. Pulse start while busy is low to hand in one
// command (send, ack or timeout check). Each result sits on the result ports
// for a single cycle, marked by result_valid, and cannot be held off, so the
// receiver must take every one.
// A send with the link down and the undefined op never raise busy. The
// link-down result comes in the cycle after the accept, and the next command
// can be accepted at once. Every other command walks the whole table through
// a single RAM read port and one shared compare unit, one entry per cycle. It
// keeps busy high while the entries are read in turn, while the read data of
// the last entry is handled, and while the scan closes. The final result,
// flagged by last, comes in the first cycle with busy low, and the next
// command can be accepted in that cycle.
// A check emits one result per due entry, in index order, the last one
// flagged by last; with nothing due it emits a single "no events" result.
// timeout_ms and retry_limit sit at byte addresses 0 and 4 of the APB port
// and are to be written only while the block is idle.
module retransmit_timeout_tracker_top #(
    parameter int TABLE_ENTRIES = rtt_pkg::TABLE_ENTRIES_DEF
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    // command
    input  wire logic                               start,
    output logic                                    busy,
    input  wire logic [rtt_pkg::OP_W-1:0]           op,
    input  wire logic [rtt_pkg::ID_W-1:0]           msg_id,
    input  wire logic [rtt_pkg::STAMP_W-1:0]        now_ms,
    input  wire logic                               link_up,
    // result
    output logic                                    result_valid,
    output logic [rtt_pkg::KIND_W-1:0]              kind,
    output logic [rtt_pkg::ID_W-1:0]                event_id,
    output logic [rtt_pkg::RETRY_W-1:0]             retry_count,
    output logic                                    was_sent,
    output logic                                    last,
    // configuration
    input  wire logic                               psel,
    input  wire logic                               penable,
    input  wire logic                               pwrite,
    input  wire logic [rtt_pkg::APB_ADDR_W-1:0]     paddr,
    input  wire logic [rtt_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [rtt_pkg::APB_DATA_W-1:0]          prdata,
    output logic                                    pready
);

    import rtt_pkg::*;

    localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

    logic [STAMP_W-1:0] timeout_reg;
    logic [RETRY_W-1:0] limit_reg;
    logic               reg_sel;
    logic               cfg_wr;

    logic               ram_re;
    logic [IDX_W-1:0]   ram_raddr;
    logic               ram_we;
    logic [IDX_W-1:0]   ram_waddr;
    rtt_entry_t         ram_wdata;
    rtt_entry_t         ram_rdata;

    logic [ID_W-1:0]    key_id;
    logic [STAMP_W-1:0] cur_now;
    rtt_cmp_t           cmp;

    // Register file
    assign pready  = 1'b1;
    assign reg_sel = paddr[2];
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_reg <= TIMEOUT_RST;
            limit_reg   <= LIMIT_RST;
        end
        else if (cfg_wr)
        begin
            if (reg_sel == REG_IDX_TIMEOUT)
            begin
                timeout_reg <= pwdata;
            end
            else
            begin
                limit_reg <= pwdata[RETRY_W-1:0];
            end
        end
    end

    always_comb
    begin
        if (reg_sel == REG_IDX_LIMIT)
        begin
            prdata = {{(APB_DATA_W - RETRY_W){1'b0}}, limit_reg};
        end
        else
        begin
            prdata = timeout_reg;
        end
    end

    // Entry table
    rtt_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_ENTRIES)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Shared compare unit
    rtt_unit u_unit (
        .entry       (ram_rdata),
        .key_id      (key_id),
        .now_ms      (cur_now),
        .timeout_ms  (timeout_reg),
        .retry_limit (limit_reg),
        .res         (cmp)
    );

    // Sequencer
    rtt_ctrl #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .op           (op),
        .msg_id       (msg_id),
        .now_ms       (now_ms),
        .link_up      (link_up),
        .result_valid (result_valid),
        .kind         (kind),
        .event_id     (event_id),
        .retry_count  (retry_count),
        .was_sent     (was_sent),
        .last         (last),
        .ram_re       (ram_re),
        .ram_raddr    (ram_raddr),
        .ram_we       (ram_we),
        .ram_waddr    (ram_waddr),
        .ram_wdata    (ram_wdata),
        .ram_rdata    (ram_rdata),
        .key_id       (key_id),
        .cur_now      (cur_now),
        .cmp          (cmp)
    );

endmodule

`default_nettype wire

// ===== verif/rtt_table_checker.sv =====
`timescale 1ns / 100ps

// Watch the command, result and register channels of the tracker, keep a
// private copy of the timer table, and compare every result transaction
// with the oldest predicted one.
module rtt_table_checker #(
    parameter int TABLE_ENTRIES = rtt_pkg::TABLE_ENTRIES_DEF
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           start,
    input  wire logic                           busy,
    input  wire logic [rtt_pkg::OP_W-1:0]       op,
    input  wire logic [rtt_pkg::ID_W-1:0]       msg_id,
    input  wire logic [rtt_pkg::STAMP_W-1:0]    now_ms,
    input  wire logic                           link_up,
    input  wire logic                           result_valid,
    input  wire logic [rtt_pkg::KIND_W-1:0]     kind,
    input  wire logic [rtt_pkg::ID_W-1:0]       event_id,
    input  wire logic [rtt_pkg::RETRY_W-1:0]    retry_count,
    input  wire logic                           was_sent,
    input  wire logic                           last,
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [rtt_pkg::APB_ADDR_W-1:0] paddr,
    input  wire logic [rtt_pkg::APB_DATA_W-1:0] pwdata,
    input  wire logic [rtt_pkg::APB_DATA_W-1:0] prdata,
    input  wire logic                           pready,
    output int                                  fail_count,
    output int                                  reports_waiting,
    output int                                  reports_seen
);

    import rtt_pkg::*;

    localparam logic [APB_ADDR_W-1:0] ADDR_TIMEOUT = {REG_IDX_TIMEOUT, 2'b00};
    localparam logic [APB_ADDR_W-1:0] ADDR_LIMIT   = {REG_IDX_LIMIT, 2'b00};

    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [ID_W-1:0]    id;
        logic [RETRY_W-1:0] retries;
        logic               sent;
        logic               last;
    } report_t;

    // Predicted registers and table
    logic [STAMP_W-1:0] timeout_reg;
    logic [RETRY_W-1:0] limit_reg;
    logic               slot_valid   [TABLE_ENTRIES];
    logic [ID_W-1:0]    slot_id      [TABLE_ENTRIES];
    logic [STAMP_W-1:0] slot_stamp   [TABLE_ENTRIES];
    logic [RETRY_W-1:0] slot_retries [TABLE_ENTRIES];

    report_t awaited_reports[$];

    function automatic report_t make_report(input logic [KIND_W-1:0] k,
                                            input logic [ID_W-1:0] id,
                                            input logic [RETRY_W-1:0] retries,
                                            input logic sent,
                                            input logic fin);
        report_t r;
        r.kind    = k;
        r.id      = id;
        r.retries = retries;
        r.sent    = sent;
        r.last    = fin;
        return r;
    endfunction

    task automatic flag_mismatch(input string msg);
        fail_count = fail_count + 1;
        if (fail_count <= 10)
        begin
            $display("[%0t] mismatch: %s", $time, msg);
        end
    endtask

    // Apply one accepted command to the table and queue the reports it causes
    task automatic predict_table_step(input logic [OP_W-1:0] cmd,
                                      input logic [ID_W-1:0] id,
                                      input logic [STAMP_W-1:0] now,
                                      input logic link);
        int                 hit;
        int                 free_slot;
        bit                 have_held;
        report_t            held;
        logic [STAMP_W-1:0] age;
        hit       = -1;
        free_slot = -1;
        have_held = 1'b0;
        held      = '0;
        for (int i = 0; i < TABLE_ENTRIES; i++)
        begin
            if (slot_valid[i] && slot_id[i] == id && hit < 0)
                hit = i;
            if (!slot_valid[i] && free_slot < 0)
                free_slot = i;
        end
        case (cmd)
            OP_SEND:
            begin
                if (!link)
                    awaited_reports.push_back(make_report(KIND_LINK_DOWN, id, '0, 1'b0, 1'b1));
                else
                begin
                    // reuse the slot of a tracked id, else take the lowest free one
                    if (hit < 0)
                        hit = free_slot;
                    if (hit < 0)
                        awaited_reports.push_back(make_report(KIND_FULL, id, '0, 1'b0, 1'b1));
                    else
                    begin
                        slot_valid[hit]   = 1'b1;
                        slot_id[hit]      = id;
                        slot_stamp[hit]   = now;
                        slot_retries[hit] = '0;
                        awaited_reports.push_back(make_report(KIND_TRACKED, id, '0, 1'b0, 1'b1));
                    end
                end
            end
            OP_ACK:
            begin
                if (hit < 0)
                    awaited_reports.push_back(make_report(KIND_ACK_UNKNOWN, id, '0, 1'b0, 1'b1));
                else
                begin
                    slot_valid[hit] = 1'b0;
                    awaited_reports.push_back(make_report(KIND_ACK_REMOVE, id, '0, 1'b0, 1'b1));
                end
            end
            OP_CHECK:
            begin
                // hold back each report one step so the final one can carry last
                for (int i = 0; i < TABLE_ENTRIES; i++)
                begin
                    age = now - slot_stamp[i];
                    if (slot_valid[i] && age > timeout_reg)
                    begin
                        if (have_held)
                            awaited_reports.push_back(held);
                        have_held = 1'b1;
                        if (slot_retries[i] < limit_reg)
                        begin
                            slot_retries[i] = slot_retries[i] + 1'b1;
                            slot_stamp[i]   = now;
                            held = make_report(KIND_RETRANSMIT, slot_id[i], slot_retries[i],
                                               link, 1'b0);
                        end
                        else
                        begin
                            slot_valid[i] = 1'b0;
                            held = make_report(KIND_GIVE_UP, slot_id[i], slot_retries[i],
                                               1'b0, 1'b0);
                        end
                    end
                end
                if (have_held)
                begin
                    held.last = 1'b1;
                    awaited_reports.push_back(held);
                end
                else
                    awaited_reports.push_back(make_report(KIND_NONE, '0, '0, 1'b0, 1'b1));
            end
            default:
            begin
                // undefined command: no report, no table change
            end
        endcase
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        report_t got;
        report_t want;
        logic [APB_DATA_W-1:0] reg_value;
        if (!rst_n)
        begin
            // Clear the table and load register reset values
            timeout_reg = TIMEOUT_RST;
            limit_reg   = LIMIT_RST;
            for (int i = 0; i < TABLE_ENTRIES; i++)
            begin
                slot_valid[i]   = 1'b0;
                slot_id[i]      = '0;
                slot_stamp[i]   = '0;
                slot_retries[i] = '0;
            end
            awaited_reports.delete();
            reports_waiting <= 0;
        end
        else
        begin
            // Track register transactions
            if (psel && penable && pready)
            begin
                if (pwrite)
                begin
                    if (paddr == ADDR_TIMEOUT)
                        timeout_reg = pwdata;
                    else if (paddr == ADDR_LIMIT)
                        limit_reg = pwdata[RETRY_W-1:0];
                end
                else
                begin
                    reg_value = (paddr == ADDR_TIMEOUT) ? timeout_reg :
                                {{(APB_DATA_W-RETRY_W){1'b0}}, limit_reg};
                    if (prdata !== reg_value)
                        flag_mismatch($sformatf("register read at %0d: expected %h, got %h",
                                                paddr, reg_value, prdata));
                end
            end

            // Predict on each accepted command
            if (start && !busy)
                predict_table_step(op, msg_id, now_ms, link_up);

            // Compare each result transaction with the oldest prediction
            if (result_valid)
            begin
                reports_seen = reports_seen + 1;
                got = make_report(kind, event_id, retry_count, was_sent, last);
                if (awaited_reports.size() == 0)
                    flag_mismatch($sformatf(
                        "unexpected result kind %0d id %h retries %0d sent %b last %b",
                        got.kind, got.id, got.retries, got.sent, got.last));
                else
                begin
                    want = awaited_reports.pop_front();
                    if (got.kind !== want.kind || got.id !== want.id ||
                        got.retries !== want.retries || got.sent !== want.sent ||
                        got.last !== want.last)
                        flag_mismatch($sformatf(
                            {"expected kind %0d id %h retries %0d sent %b last %b,",
                             " got kind %0d id %h retries %0d sent %b last %b"},
                            want.kind, want.id, want.retries, want.sent, want.last,
                            got.kind, got.id, got.retries, got.sent, got.last));
                end
            end
            reports_waiting <= awaited_reports.size();
        end
    end

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 100ps

module tb;
    import rtt_pkg::*;

    localparam int TABLE_ENTRIES = TABLE_ENTRIES_DEF;
    localparam logic [APB_ADDR_W-1:0] ADDR_TIMEOUT = {REG_IDX_TIMEOUT, 2'b00};
    localparam logic [APB_ADDR_W-1:0] ADDR_LIMIT   = {REG_IDX_LIMIT, 2'b00};
    localparam logic [OP_W-1:0]       OP_UNDEFINED = 2'd3;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  start = 1'b0;
    logic                  busy;
    logic [OP_W-1:0]       op = OP_SEND;
    logic [ID_W-1:0]       msg_id = '0;
    logic [STAMP_W-1:0]    now_ms = '0;
    logic                  link_up = 1'b0;
    logic                  result_valid;
    logic [KIND_W-1:0]     kind;
    logic [ID_W-1:0]       event_id;
    logic [RETRY_W-1:0]    retry_count;
    logic                  was_sent;
    logic                  last;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [APB_ADDR_W-1:0] paddr = '0;
    logic [APB_DATA_W-1:0] pwdata = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    int fail_count;
    int reports_waiting;
    int reports_seen;
    int commands_issued = 0;
    int settings_used = 0;
    bit steady_phase = 1'b0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    retransmit_timeout_tracker_top #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .op           (op),
        .msg_id       (msg_id),
        .now_ms       (now_ms),
        .link_up      (link_up),
        .result_valid (result_valid),
        .kind         (kind),
        .event_id     (event_id),
        .retry_count  (retry_count),
        .was_sent     (was_sent),
        .last         (last),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    rtt_table_checker #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) i_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .busy            (busy),
        .op              (op),
        .msg_id          (msg_id),
        .now_ms          (now_ms),
        .link_up         (link_up),
        .result_valid    (result_valid),
        .kind            (kind),
        .event_id        (event_id),
        .retry_count     (retry_count),
        .was_sent        (was_sent),
        .last            (last),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .fail_count      (fail_count),
        .reports_waiting (reports_waiting),
        .reports_seen    (reports_seen)
    );

    // One APB transaction; psel stays high so transfers can run back to back
    task automatic apb_transfer(input logic is_write, input logic [APB_ADDR_W-1:0] addr,
                                input logic [APB_DATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= is_write;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
    endtask

    task automatic read_registers();
        apb_transfer(1'b0, ADDR_TIMEOUT, '0);
        apb_transfer(1'b0, ADDR_LIMIT, '0);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic configure(input logic [STAMP_W-1:0] tmo, input logic [RETRY_W-1:0] lim);
        apb_transfer(1'b1, ADDR_TIMEOUT, tmo);
        apb_transfer(1'b1, ADDR_LIMIT, {{(APB_DATA_W-RETRY_W){1'b0}}, lim});
        read_registers();
        settings_used++;
    endtask

    // Hand in one command, wait for acceptance, then idle for a random gap that may be zero
    task automatic send_command(input logic [OP_W-1:0] cmd, input logic [ID_W-1:0] id,
                                input logic [STAMP_W-1:0] stamp, input logic link);
        int pick;
        int gap;
        start   <= 1'b1;
        op      <= cmd;
        msg_id  <= id;
        now_ms  <= stamp;
        link_up <= link;
        do
            @(posedge clk);
        while (busy);
        commands_issued++;
        pick = $urandom_range(0, 19);
        if (steady_phase || pick < 10)
            gap = 0;
        else if (pick < 18)
            gap = $urandom_range(1, 3);
        else
            gap = $urandom_range(8, 40);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Wait until every predicted result has come and the table walk is over
    task automatic drain();
        start <= 1'b0;
        do
            @(posedge clk);
        while (reports_waiting != 0 || busy);
        repeat (TABLE_ENTRIES + 4) @(posedge clk);
    endtask

    // Random traffic against one register setting
    task automatic run_random_phase(input logic [STAMP_W-1:0] tmo,
                                    input logic [RETRY_W-1:0] lim, input int count);
        logic [STAMP_W-1:0] stamp;
        logic [ID_W-1:0]    pool_base;
        logic [ID_W-1:0]    id;
        logic [OP_W-1:0]    cmd;
        logic               link;
        int                 pool_size;
        int                 pick;
        configure(tmo, lim);
        steady_phase = ($urandom_range(0, 3) == 0);
        stamp     = ($urandom_range(0, 3) == 0) ? 32'hFFFF_FF00 : $urandom;
        pool_base = ID_W'($urandom_range(0, 16'hFFE0));
        pool_size = $urandom_range(6, 24);
        repeat (count)
        begin
            stamp = stamp + $urandom_range(0, (tmo >> 3) + 1);
            if ($urandom_range(0, 9) != 0)
                id = ID_W'(pool_base + $urandom_range(0, pool_size - 1));
            else
                id = ID_W'($urandom_range(0, 16'hFFFF));
            link  = ($urandom_range(0, 6) != 0);
            pick  = $urandom_range(0, 99);
            if (pick < 40)
                cmd = OP_SEND;
            else if (pick < 65)
                cmd = OP_ACK;
            else if (pick < 95)
            begin
                cmd = OP_CHECK;
                // jump past the timeout half of the time so entries come due
                if ($urandom_range(0, 1) != 0)
                    stamp = stamp + tmo;
            end
            else
                cmd = OP_UNDEFINED;
            send_command(cmd, id, stamp, link);
        end
        drain();
    endtask

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // Reset values of both registers
        read_registers();
        settings_used++;

        // Directed: empty check, link down, fill, full, overwrite, acks, boundary, wrap
        send_command(OP_CHECK, '0, '0, 1'b1);
        send_command(OP_SEND, '0, '0, 1'b0);
        send_command(OP_SEND, 16'hFFFF, '0, 1'b1);
        for (int i = 0; i < TABLE_ENTRIES - 1; i++)
            send_command(OP_SEND, ID_W'(i), '0, 1'b1);
        send_command(OP_SEND, 16'h5555, '0, 1'b1);
        send_command(OP_SEND, 16'hFFFF, 32'd100, 1'b1);
        send_command(OP_ACK, 16'h1234, '0, 1'b1);
        send_command(OP_ACK, '0, '0, 1'b0);
        send_command(OP_UNDEFINED, 16'hA5A5, 32'hFFFF_FFFF, 1'b1);
        send_command(OP_CHECK, '0, 32'd5000, 1'b1);
        send_command(OP_CHECK, '0, 32'hFFFF_FFFF, 1'b0);
        drain();

        // Random traffic over extreme and typical settings
        run_random_phase(32'd1, 4'd0, 16);
        run_random_phase(32'd0, 4'd15, 16);
        run_random_phase(32'hFFFF_FFFF, 4'd15, 16);
        run_random_phase(32'd20, 4'd2, 16);
        run_random_phase(STAMP_W'($urandom_range(1, 1000)),
                         RETRY_W'($urandom_range(0, 15)), 16);
        run_random_phase(TIMEOUT_RST, LIMIT_RST, 16);

        $display("Issued %0d commands under %0d register settings: table fill, full table,",
                 commands_issued, settings_used);
        $display("overwrite, acks, timeout boundary and wrap, then random traffic;");
        $display("%0d results checked.", reports_seen);
        if (fail_count == 0 && reports_waiting == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    // Stop a hung run
    initial
    begin
        #2_000_000;
        $display("Run timed out with %0d results still awaited.", reports_waiting);
        $display("CHECK FAILED");
        $finish;
    end

endmodule
